### hw/rtl/aabb_pkg.sv
package aabb_pkg;

    // Default coordinate width; the sentinel magnitude is 2^(COORD_BITS-1) - 1.
    localparam int COORD_BITS_DEF = 25;

    // Box geometry.
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int CORNER_BITS = 3;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_POINT      = 2'd0;
    localparam logic [1:0] FUNC_GROUP_END  = 2'd1;
    localparam logic [1:0] FUNC_OBJECT_END = 2'd2;

    // Request from the input stage to the corner emitter.
    typedef struct packed {
        logic load;
        logic whole;
    } emit_ctl_t;

endpackage

### hw/rtl/aabb_box_track.sv
module aabb_box_track #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 step,
    input  logic [1:0]                                           func,
    input  logic signed [COORD_BITS-1:0]                         px,
    input  logic signed [COORD_BITS-1:0]                         py,
    input  logic signed [COORD_BITS-1:0]                         pz,
    output logic [aabb_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        snap_min,
    output logic [aabb_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        snap_max
);
    import aabb_pkg::*;

    localparam logic [COORD_BITS-1:0] LIM      = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] NEG_LIM  =
        ~LIM + {{(COORD_BITS-1){1'b0}}, 1'b1};
    localparam logic [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [NUM_AXES-1:0][COORD_BITS-1:0] raw;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] pt;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] gmin_reg, gmin_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] gmax_reg, gmax_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] omin_reg, omin_next;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] omax_reg, omax_next;

    // Saturate the one code below minus the sentinel magnitude.
    assign raw = {pz, py, px};
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pt[a] = (raw[a] == MOST_NEG) ? NEG_LIM : raw[a];
        end
    end

    // Box update for points and clearing at group and object ends.
    always_comb
    begin
        gmin_next = gmin_reg;
        gmax_next = gmax_reg;
        omin_next = omin_reg;
        omax_next = omax_reg;
        if (step)
        begin
            case (func)
                FUNC_POINT:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if ($signed(pt[a]) < $signed(gmin_reg[a]))
                            gmin_next[a] = pt[a];
                        if ($signed(gmax_reg[a]) < $signed(pt[a]))
                            gmax_next[a] = pt[a];
                        if ($signed(pt[a]) < $signed(omin_reg[a]))
                            omin_next[a] = pt[a];
                        if ($signed(omax_reg[a]) < $signed(pt[a]))
                            omax_next[a] = pt[a];
                    end
                end
                FUNC_GROUP_END:
                begin
                    gmin_next = {NUM_AXES{LIM}};
                    gmax_next = {NUM_AXES{NEG_LIM}};
                end
                FUNC_OBJECT_END:
                begin
                    gmin_next = {NUM_AXES{LIM}};
                    gmax_next = {NUM_AXES{NEG_LIM}};
                    omin_next = {NUM_AXES{LIM}};
                    omax_next = {NUM_AXES{NEG_LIM}};
                end
                default:
                begin
                end
            endcase
        end
    end

    // Box state registers, reset to the empty sentinel box.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmin_reg <= {NUM_AXES{LIM}};
            gmax_reg <= {NUM_AXES{NEG_LIM}};
            omin_reg <= {NUM_AXES{LIM}};
            omax_reg <= {NUM_AXES{NEG_LIM}};
        end
        else
        begin
            gmin_reg <= gmin_next;
            gmax_reg <= gmax_next;
            omin_reg <= omin_next;
            omax_reg <= omax_next;
        end
    end

    // The box handed to the emitter is the one the end item closes.
    assign snap_min = (func == FUNC_OBJECT_END) ? omin_reg : gmin_reg;
    assign snap_max = (func == FUNC_OBJECT_END) ? omax_reg : gmax_reg;

    // A point leaves both boxes non-empty; the assertion checks the group box on axis zero.
    a_group_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (step && func == FUNC_POINT) |=> $signed(gmin_reg[0]) <= $signed(gmax_reg[0]))
        else $error("group box inverted after a point");

    // The most negative code never enters a box.
    a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
        omin_reg[0] != MOST_NEG && omin_reg[1] != MOST_NEG && omin_reg[2] != MOST_NEG)
        else $error("unsaturated coordinate stored in object box");

endmodule

### hw/rtl/aabb_corner_emit.sv
module aabb_corner_emit #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  aabb_pkg::emit_ctl_t                                  ctl,
    input  logic [aabb_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        box_min,
    input  logic [aabb_pkg::NUM_AXES-1:0][COORD_BITS-1:0]        box_max,
    output logic                                                 can_load,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic signed [COORD_BITS-1:0]                         corner_x,
    output logic signed [COORD_BITS-1:0]                         corner_y,
    output logic signed [COORD_BITS-1:0]                         corner_z,
    output logic [aabb_pkg::CORNER_BITS-1:0]                     corner_index,
    output logic                                                 whole_object,
    output logic                                                 last_corner
);
    import aabb_pkg::*;

    localparam logic [CORNER_BITS-1:0] LAST_CORNER = CORNER_BITS'(NUM_CORNERS - 1);

    logic                                busy_reg, busy_next;
    logic [CORNER_BITS-1:0]              cnt_reg, cnt_next;
    logic                                whole_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] min_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] max_reg;
    logic                                take;

    assign take     = busy_reg && out_ready;
    assign can_load = !busy_reg || (take && cnt_reg == LAST_CORNER);

    // Corner counter: a new box starts at corner zero, each taken item steps it.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (take)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_CORNER)
                busy_next = 1'b0;
        end
        if (ctl.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Snapshot of the closed box.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            whole_reg <= ctl.whole;
            min_reg   <= box_min;
            max_reg   <= box_max;
        end
    end

    // Corner bits pick min or max on each axis.
    assign out_valid    = busy_reg;
    assign corner_x     = cnt_reg[0] ? min_reg[0] : max_reg[0];
    assign corner_y     = cnt_reg[1] ? min_reg[1] : max_reg[1];
    assign corner_z     = cnt_reg[2] ? min_reg[2] : max_reg[2];
    assign corner_index = cnt_reg;
    assign whole_object = whole_reg;
    assign last_corner  = (cnt_reg == LAST_CORNER);

    // A new box is never loaded over one still being sent.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !(out_ready && cnt_reg == LAST_CORNER)) |-> !ctl.load)
        else $error("box loaded while corners pending");

    // A taken corner that is not the last steps to the next one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cnt_reg != LAST_CORNER) |=> busy_reg && cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("corner counter did not advance");

    // The last corner taken with no new box ends the run.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cnt_reg == LAST_CORNER && !ctl.load) |=> !busy_reg)
        else $error("emitter stayed busy after last corner");

endmodule

### hw/rtl/axis_aligned_bounding_box_unit.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   func, px, py, pz
// out       out_valid / out_ready corner_x, corner_y, corner_z, corner_index,
//                                 whole_object, last_corner
//
// A point item is taken every cycle unless an end item is held; it passes an
// input register and then updates the boxes. An end item hands its box to the
// corner emitter, which sends eight result items, one per cycle while out_ready
// is high. Points keep flowing while corners are sent; a second end item waits
// in the input register until the emitter is sending its last corner.
// Reset clears the boxes to the empty sentinel box and drops all valids.
module axis_aligned_bounding_box_unit #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         func,
    input  logic signed [COORD_BITS-1:0]       px,
    input  logic signed [COORD_BITS-1:0]       py,
    input  logic signed [COORD_BITS-1:0]       pz,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [COORD_BITS-1:0]       corner_x,
    output logic signed [COORD_BITS-1:0]       corner_y,
    output logic signed [COORD_BITS-1:0]       corner_z,
    output logic [aabb_pkg::CORNER_BITS-1:0]   corner_index,
    output logic                               whole_object,
    output logic                               last_corner
);
    import aabb_pkg::*;

    logic                                in_vld_reg, in_vld_next;
    logic [1:0]                          func_reg;
    logic signed [COORD_BITS-1:0]        px_reg, py_reg, pz_reg;
    logic                                is_end;
    logic                                advance;
    logic                                can_load;
    emit_ctl_t                           ctl;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] snap_min;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] snap_max;

    // Input stage: an end item holds here until the emitter is free.
    assign is_end   = (func_reg == FUNC_GROUP_END) || (func_reg == FUNC_OBJECT_END);
    assign advance  = in_vld_reg && (!is_end || can_load);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= func;
            px_reg   <= px;
            py_reg   <= py;
            pz_reg   <= pz;
        end
    end

    // Emit request for group and object ends.
    assign ctl.load  = advance && is_end;
    assign ctl.whole = (func_reg == FUNC_OBJECT_END);

    aabb_box_track #(
        .COORD_BITS (COORD_BITS)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .func     (func_reg),
        .px       (px_reg),
        .py       (py_reg),
        .pz       (pz_reg),
        .snap_min (snap_min),
        .snap_max (snap_max)
    );

    aabb_corner_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .box_min      (snap_min),
        .box_max      (snap_max),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .corner_z     (corner_z),
        .corner_index (corner_index),
        .whole_object (whole_object),
        .last_corner  (last_corner)
    );

endmodule

### tb/tb_top.sv
import aabb_pkg::*;

// Coordinate type at the block's default width.
typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

// Function code that the block ignores.
localparam logic [1:0] FUNC_UNUSED = 2'd3;

// Sentinel magnitude and the one code below minus that magnitude.
localparam coord_t COORD_LIM      = {1'b0, {(COORD_BITS_DEF-1){1'b1}}};
localparam coord_t COORD_MOST_NEG = {1'b1, {(COORD_BITS_DEF-1){1'b0}}};

// One corner as it leaves the block.
typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
    logic [CORNER_BITS-1:0] idx;
    logic                   whole;
    logic                   last;
} corner_t;

// Tracks the group and object boxes and the corners still owed by the block.
class aabb_box_scoreboard;
    localparam int GROUP_BOX  = 0;
    localparam int OBJECT_BOX = 1;

    coord_t  box_lo[2][NUM_AXES];
    coord_t  box_hi[2][NUM_AXES];
    corner_t corners_due[$];
    int      errors;
    int      checked;

    function new();
        clear_box(GROUP_BOX);
        clear_box(OBJECT_BOX);
        errors  = 0;
        checked = 0;
    endfunction

    // An empty box has its minimum above its maximum on every axis.
    function void clear_box(int b);
        int a;
        for (a = 0; a < NUM_AXES; a++)
        begin
            box_lo[b][a] = COORD_LIM;
            box_hi[b][a] = -COORD_LIM;
        end
    endfunction

    // Queue the eight corners; bit a of the index picks the minimum on axis a.
    function void push_box(int b);
        corner_t c;
        int      k;
        for (k = 0; k < NUM_CORNERS; k++)
        begin
            c.x     = k[0] ? box_lo[b][0] : box_hi[b][0];
            c.y     = k[1] ? box_lo[b][1] : box_hi[b][1];
            c.z     = k[2] ? box_lo[b][2] : box_hi[b][2];
            c.idx   = k[CORNER_BITS-1:0];
            c.whole = (b == OBJECT_BOX);
            c.last  = (k == NUM_CORNERS - 1);
            corners_due.push_back(c);
        end
    endfunction

    // Apply one accepted input item to the boxes.
    function void note_input(logic [1:0] f, coord_t x, coord_t y, coord_t z);
        coord_t p[NUM_AXES];
        int     a;
        int     b;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        case (f)
            FUNC_POINT:
            begin
                for (a = 0; a < NUM_AXES; a++)
                begin
                    // The most negative code saturates to minus the sentinel.
                    if (p[a] == COORD_MOST_NEG)
                        p[a] = -COORD_LIM;
                    for (b = 0; b < 2; b++)
                    begin
                        if (p[a] < box_lo[b][a])
                            box_lo[b][a] = p[a];
                        if (box_hi[b][a] < p[a])
                            box_hi[b][a] = p[a];
                    end
                end
            end
            FUNC_GROUP_END:
            begin
                push_box(GROUP_BOX);
                clear_box(GROUP_BOX);
            end
            FUNC_OBJECT_END:
            begin
                // Only the object box is sent; the group box is dropped.
                push_box(OBJECT_BOX);
                clear_box(GROUP_BOX);
                clear_box(OBJECT_BOX);
            end
            default:
            begin
            end
        endcase
    endfunction

    function void report(string msg);
        if (errors < 10)
            $display("%s", msg);
        errors++;
    endfunction

    // Compare one corner from the block with the oldest one owed.
    function void check_result(corner_t got);
        corner_t want;
        string   want_s;
        string   got_s;
        if (corners_due.size() == 0)
        begin
            report($sformatf("unexpected corner: x=%0d y=%0d z=%0d idx=%0d whole=%0d last=%0d",
                             got.x, got.y, got.z, got.idx, got.whole, got.last));
            return;
        end
        want = corners_due.pop_front();
        checked++;
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.idx !== want.idx || got.whole !== want.whole || got.last !== want.last)
        begin
            want_s = $sformatf("corner mismatch: expected x=%0d y=%0d z=%0d idx=%0d whole=%0d last=%0d",
                               want.x, want.y, want.z, want.idx, want.whole, want.last);
            got_s  = $sformatf("                 got      x=%0d y=%0d z=%0d idx=%0d whole=%0d last=%0d",
                               got.x, got.y, got.z, got.idx, got.whole, got.last);
            report({want_s, "\n", got_s});
        end
    endfunction
endclass

module tb_top;

    localparam int CW             = COORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 20;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       func;
    coord_t           px;
    coord_t           py;
    coord_t           pz;
    logic             out_valid;
    logic             out_ready;
    coord_t           corner_x;
    coord_t           corner_y;
    coord_t           corner_z;
    logic [CORNER_BITS-1:0] corner_index;
    logic             whole_object;
    logic             last_corner;

    aabb_box_scoreboard sb;

    int send_idle;
    int recv_idle;
    int hold_req;
    int quiet_cycles;
    int items_sent;
    int func_seen[4];

    axis_aligned_bounding_box_unit #(
        .COORD_BITS (CW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .corner_z     (corner_z),
        .corner_index (corner_index),
        .whole_object (whole_object),
        .last_corner  (last_corner)
    );

    // Clock with a period of 20.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Coordinates: extremes, a narrow cluster around zero, or any code at all.
    function automatic coord_t rand_coord();
        logic [31:0] raw;
        int          mode;
        raw  = $urandom();
        mode = $urandom_range(0, 11);
        case (mode)
            0:       return COORD_MOST_NEG;
            1:       return COORD_LIM;
            2:       return -COORD_LIM;
            3, 4, 5, 6: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
            default: return raw[CW-1:0];
        endcase
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [1:0] f, input coord_t x, input coord_t y,
                             input coord_t z);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        px       <= x;
        py       <= y;
        pz       <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        func_seen[f]++;
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    // End items carry coordinates that the block must not look at.
    task automatic send_end(input logic [1:0] f);
        send_item(f, rand_coord(), rand_coord(), rand_coord());
    endtask

    // One object: a few groups of points, maybe loose points, then the object end.
    task automatic send_object();
        int groups;
        int npts;
        int g;
        int i;
        groups = $urandom_range(0, 3);
        for (g = 0; g < groups; g++)
        begin
            npts = $urandom_range(0, 6);
            for (i = 0; i < npts; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_end(FUNC_UNUSED);
                send_item(FUNC_POINT, rand_coord(), rand_coord(), rand_coord());
            end
            send_end(FUNC_GROUP_END);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            npts = $urandom_range(1, 4);
            for (i = 0; i < npts; i++)
                send_item(FUNC_POINT, rand_coord(), rand_coord(), rand_coord());
        end
        send_end(FUNC_OBJECT_END);
    endtask

    // Receiver: random stalls, and a long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Monitor both channels and watch for a hung block.
    always @(posedge clk)
    begin
        corner_t seen;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(func, px, py, pz);
            if (out_valid && out_ready)
            begin
                seen.x     = corner_x;
                seen.y     = corner_y;
                seen.z     = corner_z;
                seen.idx   = corner_index;
                seen.whole = whole_object;
                seen.last  = last_corner;
                sb.check_result(seen);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed items, three idle mixes of random objects.
    initial
    begin
        int ph;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_POINT;
        px           = '0;
        py           = '0;
        pz           = '0;
        hold_req     = 0;
        quiet_cycles = 0;
        items_sent   = 0;
        for (ph = 0; ph < 4; ph++)
            func_seen[ph] = 0;
        send_idle = 17;
        recv_idle = 88;
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty object and empty group give the sentinel box.
        send_end(FUNC_OBJECT_END);
        send_end(FUNC_GROUP_END);
        // Field extremes, with the most negative code saturating.
        send_item(FUNC_POINT, COORD_LIM, -COORD_LIM, coord_t'(0));
        send_item(FUNC_POINT, -COORD_LIM, COORD_LIM, COORD_MOST_NEG);
        send_item(FUNC_POINT, COORD_MOST_NEG, COORD_MOST_NEG, COORD_LIM);
        send_end(FUNC_GROUP_END);
        // A repeated point must not move a bound that it only equals.
        send_item(FUNC_POINT, coord_t'(5), coord_t'(-5), coord_t'(7));
        send_item(FUNC_POINT, coord_t'(5), coord_t'(-5), coord_t'(7));
        // The unused code changes nothing.
        send_item(FUNC_UNUSED, COORD_MOST_NEG, COORD_LIM, coord_t'(-1));
        send_item(FUNC_POINT, coord_t'(-1), coord_t'(1), coord_t'(0));
        send_end(FUNC_GROUP_END);
        // An object end drops the open group without sending it.
        send_item(FUNC_POINT, coord_t'(100), coord_t'(200), coord_t'(300));
        send_end(FUNC_OBJECT_END);
        send_end(FUNC_GROUP_END);
        // Degenerate boxes sitting on the sentinels.
        send_item(FUNC_POINT, COORD_LIM, COORD_LIM, COORD_LIM);
        send_end(FUNC_OBJECT_END);
        send_item(FUNC_POINT, COORD_MOST_NEG, -COORD_LIM, -COORD_LIM);
        send_end(FUNC_GROUP_END);
        send_end(FUNC_OBJECT_END);
        // Back-to-back end items.
        send_end(FUNC_GROUP_END);
        send_end(FUNC_OBJECT_END);

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 17;
                    recv_idle = 88;
                end
                1:
                begin
                    send_idle = 88;
                    recv_idle = 17;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    hold_req  = 1;
                end
            endcase
            while (items_sent < 150 + ph * 140)
                send_object();
        end
        in_valid <= 1'b0;

        // Drain the corners still owed, then give the block time to misbehave.
        while (sb.corners_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d points, %0d group ends, %0d object ends, %0d ignored items.",
                 func_seen[FUNC_POINT], func_seen[FUNC_GROUP_END],
                 func_seen[FUNC_OBJECT_END], func_seen[FUNC_UNUSED]);
        $display("Checked %0d corners under three stall mixes and one long output hold-off.",
                 sb.checked);
        if (sb.errors == 0 && sb.corners_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
